### design/vmt_pkg.sv
// types and constants shared by the vertex transform block
package vmt_pkg;

    localparam int unsigned COMP_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned SUM_W  = 50;
    localparam int unsigned QUO_W  = 32;

    localparam logic [1:0] MODE_DIR   = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;

    localparam logic signed [COMP_W-1:0] Q_ONE = 32'sd65536;

    localparam logic [COMP_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [COMP_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]        mode;
        logic              wz;
        logic [2:0]        neg;
        logic [COMP_W-1:0] sx;
        logic [COMP_W-1:0] sy;
        logic [COMP_W-1:0] sz;
        logic [COMP_W-1:0] sw;
    } t_side;

endpackage

### design/vmt_qdiv.sv
// pipelined restoring divider, one quotient bit per stage, Q16.16 scaled
module vmt_qdiv (
    input  logic                             i_clk,
    input  logic [vmt_pkg::SUM_W-1:0]        i_num,
    input  logic [vmt_pkg::SUM_W-1:0]        i_den,
    output logic [vmt_pkg::QUO_W-1:0]        o_quo,
    output logic                             o_ovf
);

    localparam int unsigned SW = vmt_pkg::SUM_W;
    localparam int unsigned QW = vmt_pkg::QUO_W;

    logic [SW:0]   r_rem [0:QW];
    logic [SW-1:0] r_num [0:QW];
    logic [SW-1:0] r_den [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_ovf [0:QW];

    // first partial remainder is the numerator without its 16 fraction shifts
    always_ff @(posedge i_clk) begin
        r_rem[0] <= {17'd0, i_num[SW-1:16]};
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= ({16'd0, i_num[SW-1:16]} >= i_den);
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam int J = QW - 1 - k;
            logic          nb;
            logic [SW:0]   sh;
            logic          ge;
            if (J >= 16) begin : g_nb
                assign nb = r_num[k][J-16];
            end else begin : g_zero
                assign nb = 1'b0;
            end
            assign sh = {r_rem[k][SW-1:0], nb};
            assign ge = (sh >= {1'b0, r_den[k]});
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= ge ? (sh - {1'b0, r_den[k]}) : sh;
                r_num[k+1] <= r_num[k];
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= {r_q[k][QW-2:0], ge};
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    endgenerate

    assign o_quo = r_q[QW];
    assign o_ovf = r_ovf[QW];

endmodule

### design/vertex_matrix_transform_top.sv
// top level of the 4x4 matrix vertex transform with perspective divide
// usage:
//   start with busy low transfers one vertex (mode, x, y, z, w) in; busy is
//   always low, so a vertex may enter on every cycle.
//   mode 0 applies the upper 3x3, mode 1 transforms a point and divides by
//   w, modes 2 and 3 apply the full matrix to all four components.
//   the matrix sits in eight 64-bit registers written through i_cfg_we,
//   i_cfg_idx and i_cfg_data; write them only while no vertex is in flight.
//   the pipeline delay is the same for every mode; throughput is one vertex
//   per cycle.
//   most of the pipeline is the divider, 32 stages that each resolve one
//   quotient bit, behind five stages of input, multiply, sum and sign prep.
//   each result shows on the o_ ports for one cycle with o_valid high;
//   the receiver cannot stall, every result must be taken when shown.
//   reset clears the pipeline valid bits and loads the identity matrix.
module vertex_matrix_transform_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    input  logic signed [31:0] i_in_w,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic               o_w_zero
);

    localparam int unsigned CW = vmt_pkg::COMP_W;
    localparam int unsigned PW = vmt_pkg::PROD_W;
    localparam int unsigned SW = vmt_pkg::SUM_W;
    localparam int unsigned DD = vmt_pkg::QUO_W + 1;

    logic [63:0] r_mat [0:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 64'h0000_0000_0001_0000;
            r_mat[1] <= 64'h0;
            r_mat[2] <= 64'h0001_0000_0000_0000;
            r_mat[3] <= 64'h0;
            r_mat[4] <= 64'h0;
            r_mat[5] <= 64'h0000_0000_0001_0000;
            r_mat[6] <= 64'h0;
            r_mat[7] <= 64'h0001_0000_0000_0000;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    // valid bits
    logic          r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic [DD-1:0] r_dvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r_dvld  <= '0;
            o_valid <= 1'b0;
        end else begin
            r1_vld  <= start;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r_dvld  <= {r_dvld[DD-2:0], r5_vld};
            o_valid <= r_dvld[DD-1];
        end
    end

    // input stage
    logic [1:0]           r1_mode, r2_mode, r3_mode, r4_mode;
    logic signed [CW-1:0] r1_v [0:3];

    always_ff @(posedge i_clk) begin
        r1_mode  <= i_mode;
        r1_v[0]  <= i_in_x;
        r1_v[1]  <= i_in_y;
        r1_v[2]  <= i_in_z;
        if (i_mode == vmt_pkg::MODE_DIR) begin
            r1_v[3] <= '0;
        end else if (i_mode == vmt_pkg::MODE_POINT) begin
            r1_v[3] <= vmt_pkg::Q_ONE;
        end else begin
            r1_v[3] <= i_in_w;
        end
        r2_mode <= r1_mode;
        r3_mode <= r2_mode;
        r4_mode <= r3_mode;
    end

    // products, pair sums, row sums
    logic signed [PW-1:0] r2_p [0:3][0:3];
    logic signed [PW:0]   r3_a [0:3];
    logic signed [PW:0]   r3_b [0:3];
    logic signed [SW-1:0] r4_s [0:3];

    genvar r, i;
    generate
        for (r = 0; r < 4; r++) begin : g_row
            logic signed [PW+1:0] tot;
            for (i = 0; i < 4; i++) begin : g_col
                logic signed [CW-1:0] m;
                assign m = r_mat[(4*i+r)/2][((4*i+r)%2)*32 +: 32];
                always_ff @(posedge i_clk) begin
                    r2_p[r][i] <= r1_v[i] * m;
                end
            end
            assign tot = (PW+2)'(r3_a[r]) + (PW+2)'(r3_b[r]);
            always_ff @(posedge i_clk) begin
                r3_a[r] <= (PW+1)'(r2_p[r][0]) + (PW+1)'(r2_p[r][1]);
                r3_b[r] <= (PW+1)'(r2_p[r][2]) + (PW+1)'(r2_p[r][3]);
                r4_s[r] <= tot[PW+1:16];
            end
        end
    endgenerate

    // saturate, sign and magnitude for the divide
    logic [CW-1:0] n_sat [0:3];
    logic [SW-1:0] n_abs [0:3];

    generate
        for (r = 0; r < 4; r++) begin : g_prep
            logic hi_ok;
            assign hi_ok = (r4_s[r][SW-1:CW-1] == '0) || (r4_s[r][SW-1:CW-1] == '1);
            assign n_sat[r] = hi_ok ? r4_s[r][CW-1:0]
                            : (r4_s[r][SW-1] ? vmt_pkg::SAT_MIN : vmt_pkg::SAT_MAX);
            assign n_abs[r] = r4_s[r][SW-1] ? (SW)'(-r4_s[r]) : r4_s[r];
        end
    endgenerate

    vmt_pkg::t_side       r5_side;
    logic [SW-1:0]        r5_num [0:2];
    logic [SW-1:0]        r5_den;
    vmt_pkg::t_side       r_side [0:DD-1];

    always_ff @(posedge i_clk) begin
        r5_side.mode <= r4_mode;
        r5_side.wz   <= (r4_s[3] == '0);
        r5_side.neg  <= {r4_s[2][SW-1] ^ r4_s[3][SW-1],
                         r4_s[1][SW-1] ^ r4_s[3][SW-1],
                         r4_s[0][SW-1] ^ r4_s[3][SW-1]};
        r5_side.sx   <= n_sat[0];
        r5_side.sy   <= n_sat[1];
        r5_side.sz   <= n_sat[2];
        r5_side.sw   <= n_sat[3];
        r5_num[0]    <= n_abs[0];
        r5_num[1]    <= n_abs[1];
        r5_num[2]    <= n_abs[2];
        r5_den       <= n_abs[3];
        r_side[0]    <= r5_side;
    end

    genvar d;
    generate
        for (d = 1; d < DD; d++) begin : g_delay
            always_ff @(posedge i_clk) begin
                r_side[d] <= r_side[d-1];
            end
        end
    endgenerate

    // dividers and final sign and saturation
    logic [CW-1:0] n_quo [0:2];

    generate
        for (r = 0; r < 3; r++) begin : g_div
            logic [CW-1:0] quo;
            logic          ovf;
            logic [CW:0]   mag;
            vmt_qdiv u_div (
                .i_clk (i_clk),
                .i_num (r5_num[r]),
                .i_den (r5_den),
                .o_quo (quo),
                .o_ovf (ovf)
            );
            assign mag = ovf ? {1'b1, {CW{1'b0}}} : {1'b0, quo};
            always_comb begin
                if (r_side[DD-1].neg[r]) begin
                    n_quo[r] = (mag > {1'b0, vmt_pkg::SAT_MIN}) ? vmt_pkg::SAT_MIN
                             : CW'(-mag);
                end else begin
                    n_quo[r] = (mag > {1'b0, vmt_pkg::SAT_MAX}) ? vmt_pkg::SAT_MAX
                             : mag[CW-1:0];
                end
            end
        end
    endgenerate

    vmt_pkg::t_side s_out;
    assign s_out = r_side[DD-1];

    always_ff @(posedge i_clk) begin
        if (s_out.mode == vmt_pkg::MODE_DIR) begin
            o_out_x  <= s_out.sx;
            o_out_y  <= s_out.sy;
            o_out_z  <= s_out.sz;
            o_out_w  <= '0;
            o_w_zero <= 1'b0;
        end else if (s_out.mode == vmt_pkg::MODE_POINT) begin
            o_out_x  <= s_out.wz ? '0 : n_quo[0];
            o_out_y  <= s_out.wz ? '0 : n_quo[1];
            o_out_z  <= s_out.wz ? '0 : n_quo[2];
            o_out_w  <= '0;
            o_w_zero <= s_out.wz;
        end else begin
            o_out_x  <= s_out.sx;
            o_out_y  <= s_out.sy;
            o_out_z  <= s_out.sz;
            o_out_w  <= s_out.sw;
            o_w_zero <= 1'b0;
        end
    end

endmodule

### sim/vertex_matrix_transform_top_tb.sv
// self-checking testbench for the 4x4 matrix vertex transform with perspective divide
`timescale 1ns / 1ps

module vertex_matrix_transform_top_tb;

    localparam int LATENCY   = 39;
    localparam int N_RANDOM  = 1250;
    localparam logic [2:0] REG_C0_LO = 3'd0, REG_C0_HI = 3'd1, REG_C1_LO = 3'd2,
        REG_C1_HI = 3'd3, REG_C2_LO = 3'd4, REG_C2_HI = 3'd5, REG_C3_LO = 3'd6,
        REG_C3_HI = 3'd7;
    localparam logic [1:0] MODE_FULL = 2'd2, MODE_SPARE = 2'd3;
    localparam logic [63:0] IDENT_LO = 64'h0000_0000_0001_0000;
    localparam logic [63:0] IDENT_HI = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        wz;
    } t_vtx_out;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] x, y, z, w;
        logic        known;
        t_vtx_out    res;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic signed [31:0] i_in_x, i_in_y, i_in_z, i_in_w;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [63:0]        i_cfg_data;
    logic               o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_w;
    logic               o_w_zero;

    logic [63:0] matrix_regs [8];
    t_vtx_out    pending_vertices [$];
    int          n_mismatch;
    int          idle_pct;

    vertex_matrix_transform_top u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] mentry(int k);
        logic [63:0] r;
        r = matrix_regs[k >> 1];
        return (k & 1) ? 64'(signed'(r[63:32])) : 64'(signed'(r[31:0]));
    endfunction

    function automatic logic signed [63:0] floored_row(logic signed [63:0] v[4], int n, int r);
        logic signed [127:0] acc;
        acc = '0;
        for (int i = 0; i < n; i++)
            acc += 128'(v[i]) * 128'(mentry(4 * i + r));
        return 64'(acc >>> 16);
    endfunction

    function automatic logic [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return vmt_pkg::SAT_MAX;
        if (v < -64'sd2147483648) return vmt_pkg::SAT_MIN;
        return v[31:0];
    endfunction

    function automatic logic [31:0] qdivide(logic signed [63:0] num, logic signed [63:0] den);
        logic        neg;
        logic [63:0] a, b, q;
        logic [127:0] full;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        if (a / b >= 64'd65536) q = 64'h1_0000_0000;
        else begin
            full = ({64'd0, a} << 16) / {64'd0, b};
            q = full[63:0];
        end
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(0 - q);
        end
        if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
        return q[31:0];
    endfunction

    function automatic t_vtx_out transform_vertex(logic [1:0] mode, logic [31:0] x,
                                                  logic [31:0] y, logic [31:0] z,
                                                  logic [31:0] w);
        logic signed [63:0] v[4];
        logic signed [63:0] s[4];
        t_vtx_out o;
        o = '0;
        v[0] = 64'(signed'(x));
        v[1] = 64'(signed'(y));
        v[2] = 64'(signed'(z));
        v[3] = (mode == vmt_pkg::MODE_POINT) ? 64'(vmt_pkg::Q_ONE) : 64'(signed'(w));
        if (mode == vmt_pkg::MODE_DIR) begin
            o.x = sat32(floored_row(v, 3, 0));
            o.y = sat32(floored_row(v, 3, 1));
            o.z = sat32(floored_row(v, 3, 2));
        end else if (mode == vmt_pkg::MODE_POINT) begin
            for (int r = 0; r < 4; r++) s[r] = floored_row(v, 4, r);
            if (s[3] == 0) o.wz = 1'b1;
            else begin
                o.x = qdivide(s[0], s[3]);
                o.y = qdivide(s[1], s[3]);
                o.z = qdivide(s[2], s[3]);
            end
        end else begin
            o.x = sat32(floored_row(v, 4, 0));
            o.y = sat32(floored_row(v, 4, 1));
            o.z = sat32(floored_row(v, 4, 2));
            o.w = sat32(floored_row(v, 4, 3));
        end
        return o;
    endfunction

    task automatic write_matrix_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        matrix_regs[idx] = data;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        while (pending_vertices.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // one transfer; start stays high across back-to-back items
    task automatic send_vertex(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [31:0] w, logic known = 1'b0,
                               t_vtx_out res = '0);
        t_vtx_out e;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        e = transform_vertex(mode, x, y, z, w);
        if (known && e != res)
            $display("directed row disagrees with prediction for mode %0d", mode);
        start  <= 1'b1;
        i_mode <= mode;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        i_in_w <= w;
        do @(posedge i_clk); while (busy);
        pending_vertices.push_back(known ? res : e);
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return vmt_pkg::SAT_MAX;
            1: return vmt_pkg::SAT_MIN;
            2: return 32'(signed'($urandom_range(8)) - 4) << 16;
            3: return $urandom_range(32'h0003_ffff) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_pair();
        return {rand_comp(), rand_comp()};
    endfunction

    // checker: the block cannot be stalled, so every strobe is a transfer
    always @(posedge i_clk) begin
        t_vtx_out got, want;
        if (i_rst_n && o_valid) begin
            got = {o_out_x, o_out_y, o_out_z, o_out_w, o_w_zero};
            if (pending_vertices.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_vertices.pop_front();
                if (got != want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"result mismatch: expected x=%h y=%h z=%h w=%h wz=%b,",
                                  " got x=%h y=%h z=%h w=%h wz=%b"},
                                 want.x, want.y, want.z, want.w, want.wz,
                                 got.x, got.y, got.z, got.w, got.wz);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_stim_row rows [$];
        t_stim_row row;
        logic [1:0] md;
        n_mismatch = 0;
        idle_pct   = 6;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_mode     = vmt_pkg::MODE_DIR;
        i_in_x     = '0;
        i_in_y     = '0;
        i_in_z     = '0;
        i_in_w     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_C0_LO;
        i_cfg_data = '0;
        for (int i = 0; i < 8; i++) matrix_regs[i] = '0;
        matrix_regs[REG_C0_LO] = IDENT_LO;
        matrix_regs[REG_C1_LO] = IDENT_HI;
        matrix_regs[REG_C2_HI] = IDENT_LO;
        matrix_regs[REG_C3_HI] = IDENT_HI;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset: known answers
        rows.push_back('{vmt_pkg::MODE_DIR, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                         32'h1234_5678, 1'b1,
                         '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h0, 1'b0}});
        rows.push_back('{vmt_pkg::MODE_POINT, 32'h0002_0000, 32'hfffe_0000, 32'h7fff_ffff,
                         32'h0, 1'b1,
                         '{32'h0002_0000, 32'hfffe_0000, 32'h7fff_ffff, 32'h0, 1'b0}});
        rows.push_back('{MODE_FULL, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
                         1'b1, '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 1'b0}});
        rows.push_back('{MODE_SPARE, 32'h1, 32'hffff_ffff, 32'h5555_aaaa, 32'haaaa_5555,
                         1'b1, '{32'h1, 32'hffff_ffff, 32'h5555_aaaa, 32'haaaa_5555, 1'b0}});
        rows.push_back('{vmt_pkg::MODE_DIR, 32'h0, 32'h0, 32'h0, 32'h0,
                         1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}});
        foreach (rows[i])
            send_vertex(rows[i].mode, rows[i].x, rows[i].y, rows[i].z, rows[i].w,
                        rows[i].known, rows[i].res);
        stop_sending();
        drain_results();

        // projective matrix: w row taken from z, plus extremes and zero divisor
        write_matrix_reg(REG_C2_HI, {32'hffff_0000, 32'h0001_0000});
        write_matrix_reg(REG_C3_LO, {32'h0003_0000, 32'hfff8_0000});
        write_matrix_reg(REG_C3_HI, 64'h0);
        rows.delete();
        rows.push_back('{vmt_pkg::MODE_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0,
                         1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}});
        rows.push_back('{vmt_pkg::MODE_POINT, 32'h0004_0000, 32'h0002_0000, 32'hfffe_0000,
                         32'h0, 1'b0, '0});
        rows.push_back('{vmt_pkg::MODE_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                         32'h0, 1'b0, '0});
        rows.push_back('{vmt_pkg::MODE_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
                         32'h0, 1'b0, '0});
        rows.push_back('{vmt_pkg::MODE_DIR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h0, 1'b0, '0});
        rows.push_back('{MODE_FULL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 1'b0, '0});
        foreach (rows[i])
            send_vertex(rows[i].mode, rows[i].x, rows[i].y, rows[i].z, rows[i].w,
                        rows[i].known, rows[i].res);
        stop_sending();
        drain_results();

        // extreme matrices: all max, then all min
        for (int k = 0; k < 8; k++) write_matrix_reg(3'(k), 64'h7fff_ffff_7fff_ffff);
        for (int m = 0; m < 4; m++)
            send_vertex(2'(m), vmt_pkg::SAT_MAX, vmt_pkg::SAT_MIN, vmt_pkg::SAT_MAX,
                        vmt_pkg::SAT_MIN);
        stop_sending();
        drain_results();
        for (int k = 0; k < 8; k++) write_matrix_reg(3'(k), 64'h8000_0000_8000_0000);
        for (int m = 0; m < 4; m++)
            send_vertex(2'(m), vmt_pkg::SAT_MIN, vmt_pkg::SAT_MIN, vmt_pkg::SAT_MAX,
                        vmt_pkg::SAT_MAX);
        stop_sending();
        drain_results();

        // random part in phases: each phase writes a new matrix and sets its idling rate
        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph < 2) ? 6 : (ph < 4) ? 58 : 0;
            for (int k = 0; k < 8; k++)
                write_matrix_reg(3'(k), ($urandom_range(3) == 0) ? 64'h0 : rand_pair());
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                md = ($urandom_range(9) < 4) ? vmt_pkg::MODE_POINT : 2'($urandom);
                send_vertex(md, rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
            stop_sending();
            drain_results();
        end

        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
